[rtl/core/cpd_pkg.sv]
// cpd_pkg: shared types, constants and the crc-16 byte step for the part deframer
// used by every module of the deframer and by its checker

package cpd_pkg;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PART_HDR,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PAYLOAD     = 3'd0,
		KIND_ACK         = 3'd1,
		KIND_RESEND_MSG  = 3'd2,
		KIND_RESEND_PART = 3'd3,
		KIND_DONE        = 3'd4
	} kind_t;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] NO_ID       = 16'hFFFF;
	localparam logic [7:0]  TIMEOUT_RST = 8'd36;
	localparam logic [7:0]  IDLE_MAX    = 8'hFF;

	// byte positions inside the message header and the part header
	localparam logic [2:0] HDR_ID_LO   = 3'd0;
	localparam logic [2:0] HDR_ID_HI   = 3'd1;
	localparam logic [2:0] HDR_CNT_LO  = 3'd2;
	localparam logic [2:0] HDR_CNT_HI  = 3'd3;
	localparam logic [2:0] HDR_CRC_LO  = 3'd4;
	localparam logic [2:0] HDR_CRC_HI  = 3'd5;
	localparam logic [2:0] PHDR_LEN_LO = 3'd0;
	localparam logic [2:0] PHDR_LEN_HI = 3'd1;
	localparam logic [2:0] PHDR_CRC_LO = 3'd2;
	localparam logic [2:0] PHDR_CRC_HI = 3'd3;

	localparam int MAX_RES    = 3;
	localparam int RES_IDX_W  = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       burst_end;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] id;
		logic [15:0] part;
		logic        last;
	} res_t;

	function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
		logic [7:0] x;
		x = crc[15:8] ^ b;
		x = x ^ (x >> 4);
		return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
	endfunction

	function automatic res_t mk_res(kind_t k, logic [7:0] d, logic [15:0] id,
			logic [15:0] part);
		res_t r;
		r.kind = k;
		r.data = d;
		r.id   = id;
		r.part = part;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

[rtl/core/crc_checked_part_deframer.sv]
// crc_checked_part_deframer: top level of the crc-16 checked part deframer
// depends on cpd_pkg, cpd_parser and cpd_res_fifo
//
// Takes one serial byte or timer tick per transaction and gives payload bytes, part
// acknowledges, resend requests and message-complete results, one result per transaction
// on the output channel. An input is registered, then parsed combinationally into zero
// to three results that go into a four-entry result queue. Throughput is one input per
// clock while each input gives at most one result and the output does not stall; an
// input giving two or three results leaves the single-result output port one at a time.
// An input passes the input register and result queue before its results are offered.
// The timeout register is written via the configuration channel, which is always ready.

module crc_checked_part_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  logic        burst_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic [15:0] msg_id,
	output logic [15:0] part_no,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	cpd_pkg::item_t item_s1;
	logic           valid_s1;
	logic [7:0]     timeout_q;
	logic           fire;
	logic           room;
	logic           pop;
	logic           not_empty;
	cpd_pkg::res_t  head;
	cpd_pkg::res_t  res [cpd_pkg::MAX_RES];
	logic [cpd_pkg::RES_IDX_W-1:0] res_n;
	logic [cpd_pkg::RES_IDX_W-1:0] push_n;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && room;
	assign in_ready  = !valid_s1 || fire;
	assign pop       = not_empty && out_ready;
	assign push_n    = fire ? res_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			timeout_q <= cpd_pkg::TIMEOUT_RST;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type  <= req_type;
			item_s1.data_byte <= data_byte;
			item_s1.burst_end <= burst_end;
		end
	end

	cpd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.timeout_ticks (timeout_q),
		.res           (res),
		.res_n         (res_n)
	);

	cpd_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (res),
		.push_n    (push_n),
		.pop       (pop),
		.room      (room),
		.not_empty (not_empty),
		.head      (head)
	);

	assign out_valid = not_empty;
	assign out_kind  = head.kind;
	assign out_byte  = head.data;
	assign msg_id    = head.id;
	assign part_no   = head.part;
	assign last      = head.last;

endmodule

[rtl/core/cpd_parser.sv]
// cpd_parser: header and part parsing, crc check, timeout and result generation
// depends on cpd_pkg; processes one registered item per fire, up to three results

module cpd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  cpd_pkg::item_t       item,
	input  logic [7:0]           timeout_ticks,
	output cpd_pkg::res_t        res [cpd_pkg::MAX_RES],
	output logic [cpd_pkg::RES_IDX_W-1:0] res_n
);

	cpd_pkg::phase_t phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] mid_q, mid_d;
	logic [15:0] total_q, total_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] len_q, len_d;
	logic [15:0] exp_q, exp_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] cur_q, cur_d;
	logic        disc_q, disc_d;
	logic [7:0]  idle_q, idle_d;

	logic        tick;
	logic [7:0]  b;
	logic        be;
	logic        msg_open;
	logic [7:0]  idle_inc;
	logic        timeout_ev;
	logic        take;
	logic [15:0] field_crc;
	logic        hdr_last;
	logic        hdr_bad;
	logic        hdr_zero;
	logic        phdr_last;
	logic        pay;
	logic [15:0] crc_pay;
	logic [15:0] cnt_inc;
	logic        verdict;
	logic [15:0] vcrc;
	logic [15:0] vexp;
	logic        good;
	logic [15:0] cur_inc;
	logic        complete;

	cpd_pkg::res_t res_v [cpd_pkg::MAX_RES];
	logic [cpd_pkg::RES_IDX_W-1:0] n_v;

	assign tick      = item.req_type;
	assign b         = item.data_byte;
	assign be        = item.burst_end;
	assign msg_open  = (phase_q != cpd_pkg::PH_HEADER);
	assign idle_inc  = (idle_q == cpd_pkg::IDLE_MAX) ? idle_q : idle_q + 8'd1;
	assign timeout_ev = fire && tick && msg_open && (idle_inc >= timeout_ticks);
	assign take      = fire && !tick && !disc_q;
	assign field_crc = {b, shift_q};
	assign hdr_last  = take && (phase_q == cpd_pkg::PH_HEADER)
		&& (cnt_q[2:0] == cpd_pkg::HDR_CRC_HI);
	assign hdr_bad   = hdr_last && (field_crc != crc_q);
	assign hdr_zero  = hdr_last && (field_crc == crc_q) && (total_q == 16'd0);
	assign phdr_last = take && (phase_q == cpd_pkg::PH_PART_HDR)
		&& (cnt_q[2:0] == cpd_pkg::PHDR_CRC_HI);
	assign pay       = take && (phase_q == cpd_pkg::PH_PAYLOAD);
	assign crc_pay   = cpd_pkg::crc_step(crc_q, b);
	assign cnt_inc   = cnt_q + 16'd1;
	assign verdict   = (phdr_last && (len_q == 16'd0)) || (pay && (cnt_inc >= len_q));
	assign vcrc      = pay ? crc_pay : cpd_pkg::CRC_INIT;
	assign vexp      = pay ? exp_q : field_crc;
	assign good      = (vcrc == vexp);
	assign cur_inc   = cur_q + 16'd1;
	assign complete  = verdict && good && (cur_inc == total_q);

	// result generation
	always_comb begin
		for (int k = 0; k < cpd_pkg::MAX_RES; k++) begin
			res_v[k] = '0;
		end
		n_v = '0;
		if (timeout_ev) begin
			res_v[n_v] = cpd_pkg::mk_res(cpd_pkg::KIND_RESEND_PART, 8'h00, mid_q, cur_q);
			n_v = n_v + 2'd1;
		end
		if (hdr_bad) begin
			res_v[n_v] = cpd_pkg::mk_res(cpd_pkg::KIND_RESEND_MSG, 8'h00,
				cpd_pkg::NO_ID, cpd_pkg::NO_ID);
			n_v = n_v + 2'd1;
		end
		if (hdr_zero) begin
			res_v[n_v] = cpd_pkg::mk_res(cpd_pkg::KIND_DONE, 8'h00, mid_q, 16'd0);
			n_v = n_v + 2'd1;
		end
		if (pay) begin
			res_v[n_v] = cpd_pkg::mk_res(cpd_pkg::KIND_PAYLOAD, b, mid_q, cur_q);
			n_v = n_v + 2'd1;
		end
		if (verdict) begin
			if (good) begin
				res_v[n_v] = cpd_pkg::mk_res(cpd_pkg::KIND_ACK, 8'h00, mid_q, cur_q);
			end else begin
				res_v[n_v] = cpd_pkg::mk_res(cpd_pkg::KIND_RESEND_PART, 8'h00, mid_q, cur_q);
			end
			n_v = n_v + 2'd1;
		end
		if (complete) begin
			res_v[n_v] = cpd_pkg::mk_res(cpd_pkg::KIND_DONE, 8'h00, mid_q, total_q);
			n_v = n_v + 2'd1;
		end
		for (int k = 0; k < cpd_pkg::MAX_RES; k++) begin
			res_v[k].last = (cpd_pkg::RES_IDX_W'(k) == n_v - 2'd1);
		end
	end

	assign res   = res_v;
	assign res_n = n_v;

	// next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		mid_d   = mid_q;
		total_d = total_q;
		shift_d = shift_q;
		len_d   = len_q;
		exp_d   = exp_q;
		crc_d   = crc_q;
		cur_d   = cur_q;
		disc_d  = disc_q;
		idle_d  = idle_q;

		if (fire && tick) begin
			idle_d = timeout_ev ? 8'd0 : idle_inc;
		end
		if (fire && !tick) begin
			idle_d = 8'd0;
		end
		if (timeout_ev) begin
			disc_d  = 1'b0;
			phase_d = cpd_pkg::PH_PART_HDR;
			cnt_d   = 16'd0;
			crc_d   = cpd_pkg::CRC_INIT;
		end
		if (fire && !tick && disc_q && be) begin
			disc_d = 1'b0;
		end

		if (take) begin
			unique case (phase_q)
				cpd_pkg::PH_HEADER: begin
					if (cnt_q[2:0] < cpd_pkg::HDR_CRC_LO) begin
						crc_d = crc_pay;
					end
					case (cnt_q[2:0])
						cpd_pkg::HDR_ID_LO:  mid_d   = {8'h00, b};
						cpd_pkg::HDR_ID_HI:  mid_d   = {b, mid_q[7:0]};
						cpd_pkg::HDR_CNT_LO: total_d = {8'h00, b};
						cpd_pkg::HDR_CNT_HI: total_d = {b, total_q[7:0]};
						cpd_pkg::HDR_CRC_LO: shift_d = b;
						default: ;
					endcase
					if (hdr_last) begin
						exp_d = field_crc;
						cnt_d = 16'd0;
						crc_d = cpd_pkg::CRC_INIT;
						if (hdr_bad) begin
							phase_d = cpd_pkg::PH_HEADER;
							disc_d  = !be;
						end else begin
							cur_d   = 16'd0;
							phase_d = hdr_zero ? cpd_pkg::PH_HEADER : cpd_pkg::PH_PART_HDR;
						end
					end else begin
						cnt_d = cnt_inc;
					end
				end
				cpd_pkg::PH_PART_HDR: begin
					case (cnt_q[2:0])
						cpd_pkg::PHDR_LEN_LO: len_d   = {8'h00, b};
						cpd_pkg::PHDR_LEN_HI: len_d   = {b, len_q[7:0]};
						cpd_pkg::PHDR_CRC_LO: shift_d = b;
						default: ;
					endcase
					if (phdr_last) begin
						exp_d   = field_crc;
						phase_d = cpd_pkg::PH_PAYLOAD;
						cnt_d   = 16'd0;
						crc_d   = cpd_pkg::CRC_INIT;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				cpd_pkg::PH_PAYLOAD: begin
					crc_d = crc_pay;
					cnt_d = cnt_inc;
				end
				default: ;
			endcase

			if (verdict) begin
				cnt_d = 16'd0;
				crc_d = cpd_pkg::CRC_INIT;
				if (good) begin
					cur_d   = cur_inc;
					phase_d = complete ? cpd_pkg::PH_HEADER : cpd_pkg::PH_PART_HDR;
				end else begin
					phase_d = cpd_pkg::PH_PART_HDR;
					disc_d  = !be;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cpd_pkg::PH_HEADER;
			cnt_q   <= 16'd0;
			mid_q   <= 16'd0;
			total_q <= 16'd0;
			shift_q <= 8'd0;
			len_q   <= 16'd0;
			exp_q   <= 16'd0;
			crc_q   <= cpd_pkg::CRC_INIT;
			cur_q   <= 16'd0;
			disc_q  <= 1'b0;
			idle_q  <= 8'd0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			mid_q   <= mid_d;
			total_q <= total_d;
			shift_q <= shift_d;
			len_q   <= len_d;
			exp_q   <= exp_d;
			crc_q   <= crc_d;
			cur_q   <= cur_d;
			disc_q  <= disc_d;
			idle_q  <= idle_d;
		end
	end

endmodule

[rtl/core/cpd_res_fifo.sv]
// cpd_res_fifo: four-entry result queue, takes up to three results and gives one per cycle while popped
// depends on cpd_pkg

module cpd_res_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cpd_pkg::res_t                  push_data [cpd_pkg::MAX_RES],
	input  logic [cpd_pkg::RES_IDX_W-1:0]  push_n,
	input  logic                           pop,
	output logic                           room,
	output logic                           not_empty,
	output cpd_pkg::res_t                  head
);

	cpd_pkg::res_t mem_q [cpd_pkg::FIFO_DEPTH];
	logic [cpd_pkg::FIFO_PTR_W-1:0] wr_q;
	logic [cpd_pkg::FIFO_PTR_W-1:0] rd_q;
	logic [cpd_pkg::FIFO_PTR_W:0]   cnt_q;

	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign room      = ({1'b0, cnt_q} + 4'(cpd_pkg::MAX_RES))
		<= (4'(cpd_pkg::FIFO_DEPTH) + {3'b000, pop});

	always_ff @(posedge clk) begin
		for (int k = 0; k < cpd_pkg::MAX_RES; k++) begin
			if (cpd_pkg::RES_IDX_W'(k) < push_n) begin
				mem_q[wr_q + cpd_pkg::FIFO_PTR_W'(k)] <= push_data[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + cpd_pkg::FIFO_PTR_W'(push_n);
			rd_q  <= rd_q + {{(cpd_pkg::FIFO_PTR_W-1){1'b0}}, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {{cpd_pkg::FIFO_PTR_W{1'b0}}, pop};
		end
	end

endmodule

[rtl/core/cpd_checker.sv]
// cpd_checker: port-level checks on the deframer result channel, bound to the top level
// depends on cpd_pkg

module cpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  out_kind,
	input logic [7:0]  out_byte,
	input logic [15:0] msg_id,
	input logic [15:0] part_no,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
			&& $stable(msg_id) && $stable(part_no) && $stable(last))
		else $error("result changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_kind <= cpd_pkg::KIND_DONE)
		else $error("result kind out of range");

	a_resend_msg_ids: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == cpd_pkg::KIND_RESEND_MSG |->
			msg_id == cpd_pkg::NO_ID && part_no == cpd_pkg::NO_ID && last)
		else $error("whole-message resend with bad id, part or last");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != cpd_pkg::KIND_PAYLOAD |-> out_byte == 8'h00)
		else $error("non-payload result carries a byte");

endmodule

bind crc_checked_part_deframer cpd_checker u_cpd_checker (.*);

[tb/deframe_checker.sv]
// deframe_checker: watches the input, configuration and result channels of the part deframer,
// predicts every result from its own copy of the parser state and compares field by field
// depends on cpd_pkg for the result and phase types and the header byte positions
`timescale 1ns / 100ps

module deframe_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  logic        burst_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  out_kind,
	input  logic [7:0]  out_byte,
	input  logic [15:0] msg_id,
	input  logic [15:0] part_no,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          errors,
	output int          pending
);
	import cpd_pkg::*;

	phase_t      ph;
	logic [15:0] pos;
	logic [15:0] id_q;
	logic [15:0] parts_q;
	logic [7:0]  crc_lo;
	logic [15:0] plen;
	logic [15:0] crc_want;
	logic [15:0] crc_run;
	logic [15:0] part_idx;
	logic        open_q;
	logic        skip_q;
	logic [7:0]  idle_q;
	logic [7:0]  tmo_q;

	res_t due_res[$];
	res_t held;
	logic held_v;

	function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		return r;
	endfunction

	task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
		if (errors < 100)
			$display("%0t ns: %s: expected %0h, got %0h", $time, what, want, got);
		errors = errors + 1;
	endtask

	task automatic add_res(input kind_t k, input logic [7:0] d, input logic [15:0] id,
			input logic [15:0] part);
		if (held_v)
			due_res.push_back(held);
		held.kind = k;
		held.data = d;
		held.id   = id;
		held.part = part;
		held.last = 1'b0;
		held_v = 1'b1;
	endtask

	task automatic open_part();
		ph = PH_PART_HDR;
		pos = 16'd0;
		crc_run = CRC_INIT;
	endtask

	task automatic open_header();
		ph = PH_HEADER;
		pos = 16'd0;
		crc_run = CRC_INIT;
		open_q = 1'b0;
	endtask

	task automatic part_verdict(input logic be);
		if (crc_run == crc_want) begin
			add_res(KIND_ACK, 8'h00, id_q, part_idx);
			part_idx = part_idx + 16'd1;
			if (part_idx == parts_q) begin
				add_res(KIND_DONE, 8'h00, id_q, parts_q);
				open_header();
			end else begin
				open_part();
			end
		end else begin
			add_res(KIND_RESEND_PART, 8'h00, id_q, part_idx);
			open_part();
			skip_q = !be;
		end
	endtask

	task automatic header_verdict(input logic [7:0] b, input logic be);
		crc_want = {b, crc_lo};
		if (crc_want != crc_run) begin
			add_res(KIND_RESEND_MSG, 8'h00, NO_ID, NO_ID);
			open_header();
			skip_q = !be;
		end else begin
			open_q = 1'b1;
			part_idx = 16'd0;
			if (parts_q == 16'd0) begin
				add_res(KIND_DONE, 8'h00, id_q, 16'd0);
				open_header();
			end else begin
				open_part();
			end
		end
	endtask

	task automatic take_byte(input logic [7:0] b, input logic be);
		case (ph)
		PH_HEADER: begin
			if (pos[2:0] == HDR_CRC_HI) begin
				header_verdict(b, be);
			end else begin
				crc_run = (pos < 16'd4) ? crc16_update(crc_run, b) : crc_run;
				case (pos[2:0])
				HDR_ID_LO:  id_q = {8'h00, b};
				HDR_ID_HI:  id_q[15:8] = b;
				HDR_CNT_LO: parts_q = {8'h00, b};
				HDR_CNT_HI: parts_q[15:8] = b;
				default:    crc_lo = b;
				endcase
				pos = pos + 16'd1;
			end
		end
		PH_PART_HDR: begin
			if (pos[2:0] == PHDR_CRC_HI) begin
				crc_want = {b, crc_lo};
				ph = PH_PAYLOAD;
				pos = 16'd0;
				crc_run = CRC_INIT;
				if (plen == 16'd0)
					part_verdict(be);
			end else begin
				case (pos[2:0])
				PHDR_LEN_LO: plen = {8'h00, b};
				PHDR_LEN_HI: plen[15:8] = b;
				default:     crc_lo = b;
				endcase
				pos = pos + 16'd1;
			end
		end
		PH_PAYLOAD: begin
			add_res(KIND_PAYLOAD, b, id_q, part_idx);
			crc_run = crc16_update(crc_run, b);
			pos = pos + 16'd1;
			if (pos >= plen)
				part_verdict(be);
		end
		default: ;
		endcase
	endtask

	task automatic deframe(input logic t, input logic [7:0] b, input logic be);
		held_v = 1'b0;
		if (t) begin
			if (idle_q != IDLE_MAX)
				idle_q = idle_q + 8'd1;
			if (open_q && idle_q >= tmo_q) begin
				add_res(KIND_RESEND_PART, 8'h00, id_q, part_idx);
				idle_q = 8'd0;
				skip_q = 1'b0;
				open_part();
			end
		end else begin
			idle_q = 8'd0;
			if (skip_q) begin
				if (be)
					skip_q = 1'b0;
			end else begin
				take_byte(b, be);
			end
		end
		if (held_v) begin
			held.last = 1'b1;
			due_res.push_back(held);
		end
	endtask

	task automatic check_result();
		res_t want;
		if (due_res.size() == 0) begin
			report("result with none outstanding", 16'd0, {13'd0, out_kind});
		end else begin
			want = due_res.pop_front();
			if (out_kind != want.kind)
				report("out_kind", {13'd0, want.kind}, {13'd0, out_kind});
			if (out_byte != want.data)
				report("out_byte", {8'd0, want.data}, {8'd0, out_byte});
			if (msg_id != want.id)
				report("msg_id", want.id, msg_id);
			if (part_no != want.part)
				report("part_no", want.part, part_no);
			if (last != want.last)
				report("last", {15'd0, want.last}, {15'd0, last});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_HEADER;
			pos = 16'd0;
			id_q = 16'd0;
			parts_q = 16'd0;
			crc_lo = 8'd0;
			plen = 16'd0;
			crc_want = 16'd0;
			crc_run = CRC_INIT;
			part_idx = 16'd0;
			open_q = 1'b0;
			skip_q = 1'b0;
			idle_q = 8'd0;
			tmo_q = TIMEOUT_RST;
			held_v = 1'b0;
			due_res.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				tmo_q = cfg_data;
			if (in_valid && in_ready)
				deframe(req_type, data_byte, burst_end);
			if (out_valid && out_ready)
				check_result();
			pending <= due_res.size();
		end
	end

endmodule

[tb/tb_crc_checked_part_deframer.sv]
// tb_crc_checked_part_deframer: drives framed messages, broken frames, noise and timer ticks
// into the part deframer with random gaps and output stalls, and gives the verdict
// depends on cpd_pkg, crc_checked_part_deframer and deframe_checker
`timescale 1ns / 100ps

module tb_crc_checked_part_deframer;
	import cpd_pkg::*;

	localparam logic REQ_BYTE    = 1'b0;
	localparam logic REQ_TICK    = 1'b1;
	localparam int   CYCLE_LIMIT = 800000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        req_type  = 1'b0;
	logic [7:0]  data_byte = 8'd0;
	logic        burst_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  out_kind;
	logic [7:0]  out_byte;
	logic [15:0] msg_id;
	logic [15:0] part_no;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = 8'd0;

	int   errors;
	int   pending;
	int   cycles     = 0;
	int   stall_left = 0;
	int   item_count = 0;
	logic calm       = 1'b0;
	logic [7:0] tmo  = TIMEOUT_RST;
	item_t plan[$];

	crc_checked_part_deframer dut (.*);
	deframe_checker chk (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 25)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ticks enough to trip the idle timeout, and a run that stays below it
	function automatic int expiry_run();
		return ((tmo == 8'd0) ? 1 : int'(tmo)) + $urandom_range(0, 2);
	endfunction

	function automatic int quiet_run();
		if (tmo < 8'd2)
			return 0;
		return $urandom_range(1, (tmo > 8'd10) ? 10 : int'(tmo) - 1);
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= it.req_type;
		data_byte <= it.data_byte;
		burst_end <= it.burst_end;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic flush_plan();
		item_t it;
		while (plan.size() > 0) begin
			it = plan.pop_front();
			send_item(it);
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic be);
		item_t it;
		it.req_type = REQ_BYTE;
		it.data_byte = b;
		it.burst_end = be;
		plan.push_back(it);
		item_count++;
	endtask

	task automatic add_ticks(input int n);
		item_t it;
		repeat (n) begin
			it.req_type = REQ_TICK;
			it.data_byte = 8'($urandom);
			it.burst_end = 1'($urandom);
			plan.push_back(it);
			item_count++;
		end
	endtask

	task automatic add_header(input logic [15:0] id, input logic [15:0] cnt, input logic bad,
			input logic be);
		logic [7:0]  h[4];
		logic [15:0] c;
		h = '{id[7:0], id[15:8], cnt[7:0], cnt[15:8]};
		c = CRC_INIT;
		foreach (h[i])
			c = crc_step(c, h[i]);
		if (bad)
			c = c ^ (16'd1 << $urandom_range(0, 15));
		foreach (h[i])
			add_byte(h[i], 1'b0);
		add_byte(c[7:0], 1'b0);
		add_byte(c[15:8], be);
	endtask

	// cut < 0 sends the whole part, otherwise only its first cut bytes
	task automatic add_part(input int len, input logic bad, input int cut);
		logic [7:0]  body[$];
		logic [7:0]  h[4];
		logic [15:0] c;
		logic [7:0]  b;
		logic        be;
		int          n;
		c = CRC_INIT;
		repeat (len) body.push_back(8'($urandom));
		foreach (body[i])
			c = crc_step(c, body[i]);
		if (bad)
			c = c ^ (16'd1 << $urandom_range(0, 15));
		h = '{len[7:0], len[15:8], c[7:0], c[15:8]};
		n = (cut < 0) ? len + 4 : cut;
		for (int i = 0; i < n; i++) begin
			b = (i < 4) ? h[i] : body[i - 4];
			if (i == n - 1)
				be = (cut < 0) ? ($urandom_range(0, 3) != 0) : 1'($urandom);
			else
				be = ($urandom_range(0, 31) == 0);
			add_byte(b, be);
		end
	endtask

	task automatic add_message();
		logic [15:0] id;
		int          parts;
		int          len;
		int          r;
		id = 16'($urandom);
		parts = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 4);
		add_header(id, 16'(parts), $urandom_range(0, 9) == 0, 1'($urandom));
		for (int p = 0; p < parts; p++) begin
			r = $urandom_range(0, 19);
			len = (r < 3) ? 0 : (r < 18) ? $urandom_range(1, 8) : $urandom_range(9, 24);
			if ($urandom_range(0, 5) == 0)
				add_ticks(quiet_run());
			r = $urandom_range(0, 7);
			if (r == 0) begin
				add_part(len, 1'b0, $urandom_range(0, len + 3));
				add_ticks(expiry_run());
			end else if (r == 1) begin
				add_part(len, 1'b1, -1);
			end
			add_part(len, 1'b0, -1);
		end
	endtask

	task automatic add_noise();
		repeat ($urandom_range(1, 8))
			add_byte(8'($urandom), $urandom_range(0, 3) == 0);
		if ($urandom_range(0, 1) == 1)
			add_ticks($urandom_range(1, 4));
	endtask

	task automatic random_phase(input int target);
		while (item_count < target) begin
			if ($urandom_range(0, 4) == 0)
				add_noise();
			else
				add_message();
			flush_plan();
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		tmo = v;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks with no message open, empty message, zero length part, bad header crc
		add_ticks(2);
		add_header(16'hFFFF, 16'd0, 1'b0, 1'b0);
		add_header(16'h0000, 16'd1, 1'b0, 1'b0);
		add_part(0, 1'b0, -1);
		add_header(16'h1234, 16'd1, 1'b1, 1'b1);
		flush_plan();

		settle();
		write_timeout(8'd30);
		random_phase(80);

		settle();
		write_timeout(8'd1);
		calm = 1'b1;
		random_phase(130);
		calm = 1'b0;

		settle();
		write_timeout(8'd0);
		random_phase(165);

		settle();
		write_timeout(8'($urandom_range(2, 40)));
		random_phase(230);

		settle();
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
rtl/core/cpd_pkg.sv
rtl/core/cpd_parser.sv
rtl/core/cpd_res_fifo.sv
rtl/core/crc_checked_part_deframer.sv
rtl/core/cpd_checker.sv
tb/deframe_checker.sv
tb/tb_crc_checked_part_deframer.sv
